[hw/rtl/hnps_pkg.sv]
// shared types, constants and helpers for the hamming nearest pattern search
// no dependencies
`default_nettype none
package hnps_pkg;

	localparam int MEM_DEPTH  = 256;
	localparam int WORDS      = 4;
	localparam int DIST_START = 128;

	localparam int WORD_W  = 32;
	localparam int IDX_W   = 8;
	localparam int WIDX_W  = 2;
	localparam int DIST_W  = 7;
	localparam int TIES_W  = 9;
	localparam int USED_W  = 9;
	localparam int LFSR_W  = 16;
	localparam int ADDR_W  = $clog2(MEM_DEPTH);
	localparam int POP_W   = $clog2(WORD_W + 1);
	localparam int SUM_W   = $clog2(WORDS * WORD_W + 1);

	typedef struct packed {
		logic              mode;
		logic [IDX_W-1:0]  entry;
		logic [WIDX_W-1:0] word_index;
		logic [WORD_W-1:0] word;
		logic              last;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  nearest_index;
		logic [DIST_W-1:0] distance;
		logic [TIES_W-1:0] num_ties;
	} rsp_t;

	// address token travelling down the row of cells
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] idx;
	} cell_tok_t;

	// partial distance leaving a cell
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] idx;
		logic [SUM_W-1:0]  sum;
	} cell_sum_t;

	// per-cell write strobes
	typedef struct packed {
		logic              mem_we;
		logic              query_we;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} cell_wr_t;

	function automatic logic [POP_W-1:0] pop32(input logic [WORD_W-1:0] v);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			n = n + POP_W'(v[i]);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/hnps_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module hnps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/hnps_cell.sv]
// one word lane of the search row: stored bank, query word, partial distance
// depends on hnps_pkg and hnps_ram
`default_nettype none
module hnps_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire hnps_pkg::cell_wr_t         wr,
	input  wire hnps_pkg::cell_tok_t        tok_in,
	input  wire logic [hnps_pkg::SUM_W-1:0] sum_in,
	output hnps_pkg::cell_tok_t             tok_out,
	output hnps_pkg::cell_sum_t             res_out
);

	logic [hnps_pkg::WORD_W-1:0] query_q;
	logic [hnps_pkg::WORD_W-1:0] rdata;
	hnps_pkg::cell_tok_t         tok_s1;
	hnps_pkg::cell_sum_t         res_s2;

	hnps_ram #(
		.WIDTH(hnps_pkg::WORD_W),
		.DEPTH(hnps_pkg::MEM_DEPTH)
	) u_bank (
		.clk  (clk),
		.we   (wr.mem_we),
		.waddr(wr.addr),
		.wdata(wr.data),
		.raddr(tok_in.idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (wr.query_we) begin
			query_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			res_s2 <= '0;
		end else begin
			tok_s1       <= tok_in;
			res_s2.valid <= tok_s1.valid;
			res_s2.idx   <= tok_s1.idx;
			res_s2.sum   <= sum_in + hnps_pkg::SUM_W'(hnps_pkg::pop32(rdata ^ query_q));
		end
	end

	assign tok_out = tok_s1;
	assign res_out = res_s2;

endmodule
`default_nettype wire

[hw/rtl/hamming_nearest_pattern_search.sv]
// top level: sequencer, tie selection and the row of word cells
// depends on hnps_pkg, hnps_cell, hnps_ram
// a query ending item with n used entries gives its result after a first scan
// (none when n is zero) and, when some entry lies within the bound, the 16 step
// remainder unit and a second scan. one query in flight at a time, set by the
// scans through the banks at one row per cycle and the remainder unit. reset
// clears control, entries_used and sets the lfsr to all ones; pattern banks and
// query words are undefined until written
`default_nettype none
module hamming_nearest_pattern_search (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire hnps_pkg::req_t              req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output hnps_pkg::rsp_t                   rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [hnps_pkg::USED_W-1:0] cfg_data
);

	localparam int INF_W = $clog2(hnps_pkg::WORDS + 3);
	localparam int DCNT_W = $clog2(hnps_pkg::LFSR_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                          state_q;
	logic [hnps_pkg::USED_W-1:0]     used_cfg_q;
	logic [hnps_pkg::USED_W-1:0]     used_q;
	logic [hnps_pkg::USED_W-1:0]     used_n;
	logic [hnps_pkg::LFSR_W-1:0]     lfsr_q;
	logic [hnps_pkg::LFSR_W-1:0]     lfsr_adv;
	logic [hnps_pkg::ADDR_W-1:0]     addr_q;
	logic [INF_W-1:0]                inflight_q;
	logic                            pass2_q;
	logic                            found_q;
	logic [hnps_pkg::SUM_W-1:0]      best_q;
	logic [hnps_pkg::TIES_W-1:0]     ties_q;
	logic [hnps_pkg::TIES_W-1:0]     seen_q;
	logic [hnps_pkg::ADDR_W-1:0]     chosen_q;
	logic [hnps_pkg::TIES_W:0]       rem_q;
	logic [hnps_pkg::TIES_W:0]       rem_try;
	logic [hnps_pkg::LFSR_W-1:0]     div_src_q;
	logic [DCNT_W-1:0]               div_cnt_q;
	logic                            rsp_valid_q;
	hnps_pkg::rsp_t                  rsp_q;
	logic                            req_acc;
	logic                            issue;

	hnps_pkg::cell_tok_t             tok   [hnps_pkg::WORDS+1];
	hnps_pkg::cell_sum_t             res   [hnps_pkg::WORDS];
	hnps_pkg::cell_wr_t              wr    [hnps_pkg::WORDS];
	hnps_pkg::cell_sum_t             chain_out;

	// only idle takes items; results wait in the output register
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// clamp the entry count to the bank depth
	assign used_n = (32'(used_cfg_q) > hnps_pkg::MEM_DEPTH) ?
		hnps_pkg::USED_W'(hnps_pkg::MEM_DEPTH) : used_cfg_q;

	// x^16+x^14+x^13+x^11+1, shifting right
	assign lfsr_adv = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

	// one restoring step of lfsr mod ties
	always_comb begin
		rem_try = {rem_q[hnps_pkg::TIES_W-1:0], div_src_q[hnps_pkg::LFSR_W-1]};
		if (rem_try >= {1'b0, ties_q}) begin
			rem_try = rem_try - {1'b0, ties_q};
		end
	end

	// address token enters the first cell, one row per cycle
	assign issue         = (state_q == ST_SCAN);
	assign tok[0].valid  = issue;
	assign tok[0].idx    = addr_q;

	for (genvar k = 0; k < hnps_pkg::WORDS; k++) begin : g_cell
		always_comb begin
			wr[k].mem_we   = req_acc && !req.mode && (int'(req.word_index) == k) &&
				(int'(req.entry) < hnps_pkg::MEM_DEPTH);
			wr[k].query_we = req_acc && req.mode && (int'(req.word_index) == k);
			wr[k].addr     = hnps_pkg::ADDR_W'(req.entry);
			wr[k].data     = req.word;
		end

		hnps_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr     (wr[k]),
			.tok_in (tok[k]),
			.sum_in ((k == 0) ? '0 : res[(k == 0) ? 0 : k-1].sum),
			.tok_out(tok[k+1]),
			.res_out(res[k])
		);
	end

	// full distance for one entry leaves the last cell
	assign chain_out = res[hnps_pkg::WORDS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_cfg_q  <= '0;
			lfsr_q      <= '1;
			inflight_q  <= '0;
			pass2_q     <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				used_cfg_q <= cfg_data;
			end
			// the final state loads the next item itself
			if (rsp_valid_q && !rsp_stall && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			inflight_q <= inflight_q + INF_W'(issue) - INF_W'(chain_out.valid);

			// collect distances: first pass finds the minimum, second picks the tie
			if (chain_out.valid) begin
				if (!pass2_q) begin
					if (chain_out.sum < best_q) begin
						best_q <= chain_out.sum;
						ties_q <= hnps_pkg::TIES_W'(1);
					end else if (chain_out.sum == best_q) begin
						ties_q <= ties_q + 1'b1;
					end
				end else if (chain_out.sum == best_q) begin
					if (!found_q && seen_q == rem_q[hnps_pkg::TIES_W-1:0]) begin
						chosen_q <= chain_out.idx;
						found_q  <= 1'b1;
					end
					seen_q <= seen_q + 1'b1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && req.mode && req.last) begin
						lfsr_q  <= lfsr_adv;
						used_q  <= used_n;
						best_q  <= hnps_pkg::SUM_W'(hnps_pkg::DIST_START - 1);
						ties_q  <= '0;
						pass2_q <= 1'b0;
						found_q <= 1'b0;
						addr_q  <= '0;
						state_q <= (used_n == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (hnps_pkg::USED_W'(addr_q) + 1'b1 == used_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (inflight_q == '0) begin
						if (pass2_q || ties_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							rem_q     <= '0;
							div_src_q <= lfsr_q;
							div_cnt_q <= '0;
							state_q   <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q     <= rem_try;
					div_src_q <= div_src_q << 1;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCNT_W'(hnps_pkg::LFSR_W - 1)) begin
						pass2_q <= 1'b1;
						seen_q  <= '0;
						addr_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.nearest_index <= found_q ? hnps_pkg::IDX_W'(chosen_q) : '0;
						rsp_q.distance      <= hnps_pkg::DIST_W'(best_q);
						rsp_q.num_ties      <= (ties_q == '0) ? hnps_pkg::TIES_W'(1) : ties_q;
						rsp_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a result never reports zero ties
	a_ties_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.num_ties != '0))
		else $error("result with zero ties");

	// distances only come back while a scan is running or draining
	a_res_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance outside a scan");

	// the row never holds more tokens than its depth
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(inflight_q) <= hnps_pkg::WORDS + 2)
		else $error("too many rows in flight");

	// a second pass with ties always finds its pick
	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && pass2_q) |-> found_q)
		else $error("tied entry not selected");

endmodule
`default_nettype wire

[test/hnps_checker.sv]
`timescale 1ns / 100ps
// checker for hamming_nearest_pattern_search: watches the request, result and
// register channels, predicts each search result and compares it
// depends on hnps_pkg
module hnps_checker
	import hnps_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_stall,
	input  wire req_t              req,
	input  wire logic              rsp_valid,
	input  wire logic              rsp_stall,
	input  wire rsp_t              rsp,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [USED_W-1:0] cfg_data,
	output int                     failures,
	output int                     pending
);

	logic [WORD_W-1:0] pattern_mem [MEM_DEPTH][WORDS];
	logic [WORD_W-1:0] query_words [WORDS];
	logic [LFSR_W-1:0] tie_seq;
	logic [USED_W-1:0] used_entries;
	rsp_t              nearest_q [$];

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
		failures++;
	endtask

	function automatic int entry_dist(input int e);
		int d;
		d = 0;
		for (int w = 0; w < WORDS; w++) begin
			d += $countones(pattern_mem[e][w] ^ query_words[w]);
		end
		return d;
	endfunction

	function automatic rsp_t nearest_search();
		int   lim, best, ties, pick, seen, chosen;
		rsp_t r;
		lim = (used_entries > MEM_DEPTH) ? MEM_DEPTH : int'(used_entries);
		best = DIST_START - 1;
		ties = 0;
		chosen = 0;
		for (int e = 0; e < lim; e++) begin
			if (entry_dist(e) < best) begin
				best = entry_dist(e);
				ties = 1;
			end else if (entry_dist(e) == best) begin
				ties++;
			end
		end
		if (ties == 0) begin
			ties = 1;
		end else begin
			pick = int'(tie_seq) % ties;
			seen = 0;
			for (int e = 0; e < lim; e++) begin
				if (entry_dist(e) == best) begin
					if (seen == pick) begin
						chosen = e;
						break;
					end
					seen++;
				end
			end
		end
		r.nearest_index = IDX_W'(chosen);
		r.distance = DIST_W'(best);
		r.num_ties = TIES_W'(ties);
		return r;
	endfunction

	initial begin
		failures = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			tie_seq = '1;
			used_entries = '0;
			nearest_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				used_entries = cfg_data;
			end
			if (rsp_valid && !rsp_stall) begin
				if (nearest_q.size() == 0) begin
					report("results with no search pending", 1, 0);
				end else begin
					want = nearest_q.pop_front();
					if (rsp.nearest_index !== want.nearest_index)
						report("nearest_index", rsp.nearest_index, want.nearest_index);
					if (rsp.distance !== want.distance)
						report("distance", rsp.distance, want.distance);
					if (rsp.num_ties !== want.num_ties)
						report("num_ties", rsp.num_ties, want.num_ties);
				end
			end
			if (req_valid && !req_stall) begin
				if (!req.mode) begin
					pattern_mem[req.entry][req.word_index] = req.word;
				end else begin
					query_words[req.word_index] = req.word;
					if (req.last) begin
						tie_seq = {tie_seq[0] ^ tie_seq[2] ^ tie_seq[3] ^ tie_seq[5],
							tie_seq[15:1]};
						nearest_q.push_back(nearest_search());
					end
				end
			end
			pending = nearest_q.size();
		end
	end

endmodule

[test/tb_hamming_nearest_pattern_search.sv]
`timescale 1ns / 100ps
// testbench top for hamming_nearest_pattern_search: drives stored words,
// queries and entries_used, and gives the verdict
// depends on hnps_pkg, hamming_nearest_pattern_search, hnps_checker
module tb_hamming_nearest_pattern_search;
	import hnps_pkg::*;

	localparam int IDLE_LIMIT = 4000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [USED_W-1:0] cfg_data = '0;
	int                failures;
	int                pending;

	// no random idling on either side while this is set
	logic              calm = 1'b0;
	// per entry, which words have been written at least once
	logic [WORDS-1:0]  written [MEM_DEPTH];
	// entries 0..filled-1 are fully written and may be searched
	int                filled = 0;
	int                sent = 0;
	int                idle_cycles = 0;
	logic [WORD_W-1:0] palette [4];

	always #10 clk = ~clk;

	hamming_nearest_pattern_search dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	hnps_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.failures(failures), .pending(pending)
	);

	// result side: stall at random, never during the calm stretch
	always @(negedge clk) begin
		rsp_stall = !calm && ($urandom_range(0, 99) < 19);
	end

	// watchdog: cycles in which no channel moves anything
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one item on the request channel, with random gaps before it
	task automatic send(input logic m, input int e, input int wi,
			input logic [WORD_W-1:0] w, input logic l);
		calm = (sent > 450 && sent < 650);
		while (!calm && $urandom_range(0, 99) < 19) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req.mode = m;
		req.entry = IDX_W'(e);
		req.word_index = WIDX_W'(wi);
		req.word = w;
		req.last = l;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		req_valid = 1'b0;
		sent++;
		if (!m)
			written[e][wi] = 1'b1;
		while (filled < MEM_DEPTH && written[filled] == '1)
			filled++;
	endtask

	task automatic set_used(input int v);
		// no search may be running, and a write must land first
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = USED_W'(v);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly words from a small palette so that distances tie often
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		w = palette[$urandom_range(0, 3)];
		case ($urandom_range(0, 9))
			0, 1, 2: w = $urandom();
			3, 4:    w = w ^ (32'h1 << $urandom_range(0, 31));
			default: ;
		endcase
		return w;
	endfunction

	// one query: all words in shuffled order, last on the final one
	task automatic query_burst();
		int order [WORDS];
		int j, t;
		for (int i = 0; i < WORDS; i++)
			order[i] = i;
		for (int i = WORDS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < WORDS; i++) begin
			send(1'b1, $urandom_range(0, 255), order[i], pick_word(), i == WORDS - 1);
		end
	endtask

	initial begin
		int target, nq;
		logic [WORD_W-1:0] q [WORDS];
		for (int i = 0; i < MEM_DEPTH; i++)
			written[i] = '0;
		palette[0] = '0;
		palette[1] = '1;
		palette[2] = 32'h5A5A_C3C3;
		palette[3] = ~32'h5A5A_C3C3;
		q[0] = '0;
		q[1] = '1;
		q[2] = 32'hA5A5_0F0F;
		q[3] = 32'h1234_8001;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no entries: index 0, start bound, one tie
		set_used(0);
		for (int i = 0; i < WORDS; i++)
			send(1'b1, 255, i, q[i], i == WORDS - 1);
		// one entry that differs in every bit: nothing qualifies
		for (int i = 0; i < WORDS; i++)
			send(1'b0, 0, i, ~q[i], 1'b1);
		set_used(1);
		send(1'b1, 0, 3, q[3], 1'b1);
		// one bit back: distance exactly at the start bound still counts
		send(1'b0, 0, 0, ~q[0] ^ 32'h8000_0000, 1'b0);
		send(1'b1, 0, 3, q[3], 1'b1);
		// top entry, exact match, and a query word without last
		for (int i = 0; i < WORDS; i++)
			send(1'b0, 1, i, q[i], 1'b0);
		send(1'b0, 255, 3, '1, 1'b1);
		set_used(2);
		send(1'b1, 7, 2, q[2], 1'b0);
		send(1'b1, 7, 3, q[3], 1'b1);

		// random phases, each with its own entries_used
		for (int ph = 0; sent < 1150; ph++) begin
			case (ph % 9)
				2:       target = MEM_DEPTH;
				5:       target = 511;
				4, 7:    target = $urandom_range(0, 2);
				default: target = $urandom_range(3, 40);
			endcase
			// every searched entry must be written first
			for (int e = 0; e < ((target > MEM_DEPTH) ? MEM_DEPTH : target); e++)
				for (int w = 0; w < WORDS; w++)
					if (!written[e][w])
						send(1'b0, e, w, pick_word(), 1'($urandom_range(0, 1)));
			set_used(target);
			nq = (target >= MEM_DEPTH) ? 6 : 25;
			for (int k = 0; k < nq; k++) begin
				if ($urandom_range(0, 99) < 80) begin
					query_burst();
				end else begin
					// noise: lone query words and rewrites of any entry
					send(1'($urandom_range(0, 1)), $urandom_range(0, 255),
						$urandom_range(0, 3), pick_word(), 1'($urandom_range(0, 1)));
				end
				if ($urandom_range(0, 99) < 30) begin
					send(1'b0, $urandom_range(0, 255), $urandom_range(0, 3),
						pick_word(), 1'($urandom_range(0, 1)));
				end
			end
		end
		calm = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (600) @(posedge clk);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
